FILE: rtl/dc_pkg.sv
// dc_pkg: shared types, constants and helpers for the divisor count block
// depends on nothing; imported by dc_rem_unit and divisor_count
`timescale 1ns / 1ps
`default_nettype none

package dc_pkg;

    // default operand width
    localparam int DC_WIDTH_DEF = 32;

    // width of the input port field
    localparam int IN_W = 32;

    // result field
    localparam int TOTAL_W = 11;
    localparam logic [TOTAL_W-1:0] TOTAL_ONE = TOTAL_W'(1);
    localparam logic [TOTAL_W-1:0] TOTAL_TWO = TOTAL_W'(2);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // increments applied to the count
    localparam logic [1:0] INC_ROOT = 2'd1;
    localparam logic [1:0] INC_PAIR = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WAIT,
        S_FIN
    } t_state;

    // status from the remainder unit
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_rem_stat;

    // add with saturation at the top of the result field
    function automatic logic [TOTAL_W-1:0] f_sat_add(input logic [TOTAL_W-1:0] a,
                                                      input logic [1:0] inc);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, a} + {{(TOTAL_W-1){1'b0}}, inc};
        if (sum[TOTAL_W]) begin
            return TOTAL_MAX;
        end
        return sum[TOTAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dc_rem_unit.sv
// dc_rem_unit: iterative restoring remainder unit, one quotient bit per cycle
// depends on dc_pkg (t_rem_stat)
`timescale 1ns / 1ps
`default_nettype none

module dc_rem_unit #(
    parameter int WIDTH = dc_pkg::DC_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_dividend,
    input  wire logic [WIDTH-1:0] i_divisor,
    output dc_pkg::t_rem_stat     o_stat
);
    import dc_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_shift;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    // shift in the next dividend bit and try the subtraction
    assign trial = {r_rem, r_shift[WIDTH-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign fits  = (trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt   <= CNT_W'(WIDTH);
            r_rem   <= '0;
            r_shift <= i_dividend;
        end else if (r_busy) begin
            r_cnt   <= r_cnt - CNT_W'(1);
            r_rem   <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            r_shift <= {r_shift[WIDTH-2:0], 1'b0};
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = (r_rem == '0);

endmodule

`default_nettype wire

FILE: rtl/divisor_count.sv
// divisor_count: counts the positive divisors of a signed integer by trial division
// depends on dc_pkg and dc_rem_unit
`timescale 1ns / 1ps
`default_nettype none

// Takes one signed value per transfer and returns one result transfer holding
// the number of its positive divisors. Values of 1 or less (zero and all
// negatives) give 1. Otherwise the count starts at 2 and every trial divisor d
// from 2 with d*d below the value adds 2 when it divides the value; a perfect
// square adds 1 for its root. Counts saturate at 2047. The operand is the low
// WIDTH bits of i_value with bit WIDTH-1 as sign; above 32 bits it is zero
// extended. One item is worked on at a time and o_stall stays high until its
// result has moved into the output register, which may still wait on i_stall
// while the next item is taken in. Each trial divisor takes a compare in
// S_CHECK, a run of the bit-serial remainder unit and the fold-in of its
// result in S_WAIT.
module divisor_count #(
    parameter int WIDTH = dc_pkg::DC_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input channel
    input  wire logic                           i_valid,
    input  wire logic signed [dc_pkg::IN_W-1:0] i_value,
    output logic                                o_stall,
    // output channel
    output logic                                o_valid,
    output logic [dc_pkg::TOTAL_W-1:0]          o_divisor_total,
    input  wire logic                           i_stall
);
    import dc_pkg::*;

    // square register needs headroom for (d+1)^2 just past the operand
    localparam int SQ_W = WIDTH + 2;

    t_state             r_state, n_state;
    logic [WIDTH-1:0]   r_n, n_n;       // operand under test
    logic [WIDTH-1:0]   r_d, n_d;       // current trial divisor
    logic [SQ_W-1:0]    r_sq, n_sq;     // d*d kept by increments
    logic [TOTAL_W-1:0] r_count, n_count;
    logic               r_out_valid, n_out_valid;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;

    logic [WIDTH-1:0]   operand;
    logic               trivial;
    logic               in_xfer;
    logic               out_xfer;
    logic               rem_start;
    t_rem_stat          rem_stat;
    logic [SQ_W-1:0]    sq_step;
    logic [SQ_W-1:0]    n_ext;

    // operand taken from the port: truncate or zero extend to WIDTH bits
    generate
        if (WIDTH <= IN_W) begin : g_trunc
            assign operand = i_value[WIDTH-1:0];
        end else begin : g_ext
            assign operand = {{(WIDTH-IN_W){1'b0}}, i_value};
        end
    endgenerate

    // negative, zero and one all give a count of 1
    assign trivial = operand[WIDTH-1] || (operand[WIDTH-1:1] == '0);

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;

    // (d+1)^2 = d^2 + 2d + 1
    assign sq_step = SQ_W'({r_d, 1'b1});
    assign n_ext   = SQ_W'(r_n);

    dc_rem_unit #(
        .WIDTH(WIDTH)
    ) u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (rem_start),
        .i_dividend(r_n),
        .i_divisor (r_d),
        .o_stat    (rem_stat)
    );

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_d         <= n_d;
        r_sq        <= n_sq;
        r_count     <= n_count;
        r_out_total <= n_out_total;
    end

    // sequencer: next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_d         = r_d;
        n_sq        = r_sq;
        n_count     = r_count;
        n_out_total = r_out_total;
        rem_start   = 1'b0;
        // result leaves the output register on a transfer
        n_out_valid = r_out_valid && !out_xfer;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_n  = operand;
                    n_d  = WIDTH'(2);
                    n_sq = SQ_W'(4);
                    if (trivial) begin
                        n_count = TOTAL_ONE;
                        n_state = S_FIN;
                    end else begin
                        n_count = TOTAL_TWO;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_sq < n_ext) begin
                    // launch the remainder test for this divisor
                    rem_start = 1'b1;
                    n_state   = S_WAIT;
                end else begin
                    // loop over; add the root of a perfect square
                    if (r_sq == n_ext) begin
                        n_count = f_sat_add(r_count, INC_ROOT);
                    end
                    n_state = S_FIN;
                end
            end
            S_WAIT: begin
                if (rem_stat.done) begin
                    if (rem_stat.rem_zero) begin
                        // d and n/d both divide
                        n_count = f_sat_add(r_count, INC_PAIR);
                    end
                    n_d     = r_d + WIDTH'(1);
                    n_sq    = r_sq + sq_step;
                    n_state = S_CHECK;
                end
            end
            S_FIN: begin
                // hand the count over once the output register is free
                if (!r_out_valid || out_xfer) begin
                    n_out_valid = 1'b1;
                    n_out_total = r_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_divisor_total = r_out_total;

endmodule

`default_nettype wire
